// ----- rtl/mtd_pkg.sv -----
// Shared types and constants of the modem online data path.
`default_nettype none

package mtd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned IdleW = 17;

  localparam logic [CfgIdxW-1:0] RegTelnetMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGuardTicks = 2'd1;

  localparam logic [15:0] GuardReset = 16'd1000;
  localparam logic [IdleW-1:0] IdleMax = 17'h10000;

  localparam logic [7:0] ByteIac = 8'hFF;
  localparam logic [7:0] ByteWill = 8'd251;
  localparam logic [7:0] ByteWont = 8'd252;
  localparam logic [7:0] ByteDo = 8'd253;
  localparam logic [7:0] ByteDont = 8'd254;
  localparam logic [7:0] BytePlus = 8'h2B;

  typedef enum logic [2:0] {
    OP_SERIAL  = 3'd0,
    OP_NETWORK = 3'd1,
    OP_TICK    = 3'd2,
    OP_ONLINE  = 3'd3,
    OP_CARRIER = 3'd4
  } mtd_op_e;

  // Telnet receive state; the two codes above IAC_DONT act as idle.
  typedef enum logic [2:0] {
    IAC_IDLE = 3'd0,
    IAC_SEEN = 3'd1,
    IAC_WILL = 3'd2,
    IAC_WONT = 3'd3,
    IAC_DO   = 3'd4,
    IAC_DONT = 3'd5
  } mtd_iac_e;

  typedef struct packed {
    logic       to_network;
    logic [7:0] out_byte;
    logic       escape_notice;
  } mtd_res_t;

  typedef struct packed {
    logic [1:0]     cnt;
    mtd_res_t [2:0] res;
  } mtd_burst_t;

endpackage

`default_nettype wire

// ----- rtl/mtd_if.sv -----
// Handshake channels of the modem online data path.
`default_nettype none

interface mtd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] data_byte;
  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface mtd_out_if;
  logic       valid;
  logic       ready;
  logic       to_network;
  logic [7:0] out_byte;
  logic       escape_notice;
  logic       last;
  modport source (output valid, output to_network, output out_byte,
                  output escape_notice, output last, input ready);
  modport sink (input valid, input to_network, input out_byte,
                input escape_notice, input last, output ready);
endinterface

interface mtd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/mtd_core.sv -----
// Escape detection, telnet filtering and mode state for one request.
`default_nettype none

module mtd_core import mtd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                step_i,
  input  wire logic [2:0]          opcode_i,
  input  wire logic [7:0]          data_byte_i,
  output mtd_burst_t               burst_o
);

  logic             telnet_q;
  logic [15:0]      guard_q;
  logic             online_q, online_d;
  logic [1:0]       plus_q, plus_d;
  logic [IdleW-1:0] idle_q, idle_d;
  mtd_iac_e         iac_q, iac_d;

  logic       plus_hit;
  logic [7:0] reply;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      telnet_q <= 1'b0;
      guard_q  <= GuardReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegTelnetMode) begin
        telnet_q <= cfg_data_i[0];
      end else if (cfg_index_i == RegGuardTicks) begin
        guard_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q <= 1'b0;
      plus_q   <= 2'd0;
      idle_q   <= '0;
      iac_q    <= IAC_IDLE;
    end else if (step_i) begin
      online_q <= online_d;
      plus_q   <= plus_d;
      idle_q   <= idle_d;
      iac_q    <= iac_d;
    end
  end

  // A plus counts when a run is under way or the line was quiet long enough.
  assign plus_hit = (data_byte_i == BytePlus) &&
                    ((plus_q != 2'd0) || (idle_q > {1'b0, guard_q}));

  always_comb begin
    online_d = online_q;
    plus_d   = plus_q;
    idle_d   = idle_q;
    iac_d    = iac_q;
    reply    = 8'd0;
    burst_o  = '0;
    unique case (mtd_op_e'(opcode_i))
      OP_SERIAL: begin
        if (online_q) begin
          idle_d = '0;
          if (plus_hit && plus_q == 2'd2) begin
            plus_d = 2'd0;
            online_d = 1'b0;
            burst_o.cnt = 2'd1;
            burst_o.res[0] = '{to_network: 1'b0, out_byte: 8'd0, escape_notice: 1'b1};
          end else begin
            plus_d = plus_hit ? plus_q + 2'd1 : 2'd0;
            burst_o.cnt = 2'd1;
            burst_o.res[0] = '{to_network: 1'b1, out_byte: data_byte_i, escape_notice: 1'b0};
            if (telnet_q && data_byte_i == ByteIac) begin
              burst_o.cnt = 2'd2;
              burst_o.res[1] = burst_o.res[0];
            end
          end
        end
      end
      OP_NETWORK: begin
        if (online_q) begin
          if (!telnet_q) begin
            burst_o.cnt = 2'd1;
            burst_o.res[0] = '{to_network: 1'b0, out_byte: data_byte_i, escape_notice: 1'b0};
          end else begin
            case (iac_q)
              IAC_SEEN: begin
                iac_d = IAC_IDLE;
                if (data_byte_i == ByteIac) begin
                  burst_o.cnt = 2'd1;
                  burst_o.res[0] = '{to_network: 1'b0, out_byte: ByteIac,
                                     escape_notice: 1'b0};
                end else if (data_byte_i >= ByteWill && data_byte_i <= ByteDont) begin
                  // Verb codes 251 to 254 map onto the four verb states.
                  iac_d = mtd_iac_e'(data_byte_i[2:0] - 3'd1);
                end
              end
              IAC_WILL, IAC_WONT, IAC_DO, IAC_DONT: begin
                iac_d = IAC_IDLE;
                if (iac_q == IAC_WILL || iac_q == IAC_DO) begin
                  reply = (iac_q == IAC_DO) ? ByteWont : ByteDont;
                  burst_o.cnt = 2'd3;
                  burst_o.res[0] = '{to_network: 1'b1, out_byte: ByteIac,
                                     escape_notice: 1'b0};
                  burst_o.res[1] = '{to_network: 1'b1, out_byte: reply,
                                     escape_notice: 1'b0};
                  burst_o.res[2] = '{to_network: 1'b1, out_byte: data_byte_i,
                                     escape_notice: 1'b0};
                end
              end
              default: begin
                if (data_byte_i == ByteIac) begin
                  iac_d = IAC_SEEN;
                end else begin
                  burst_o.cnt = 2'd1;
                  burst_o.res[0] = '{to_network: 1'b0, out_byte: data_byte_i,
                                     escape_notice: 1'b0};
                end
              end
            endcase
          end
        end
      end
      OP_TICK: begin
        if (idle_q < IdleMax) begin
          idle_d = idle_q + 1'b1;
        end
      end
      OP_ONLINE: begin
        online_d = 1'b1;
        idle_d = '0;
        plus_d = 2'd0;
      end
      OP_CARRIER: begin
        online_d = 1'b0;
        plus_d = 2'd0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mtd_out.sv -----
// Result register; hands out results one per cycle while ready_i is high.
`default_nettype none

module mtd_out import mtd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire mtd_burst_t burst_i,
  output logic            can_load_o,
  output logic            valid_o,
  input  wire logic       ready_i,
  output mtd_res_t        res_o,
  output logic            last_o
);

  mtd_res_t [2:0] ent_q;
  logic [1:0]     cnt_q, cnt_d;
  logic [1:0]     idx_q, idx_d;
  logic           pop;

  assign valid_o = (cnt_q != 2'd0);
  assign last_o = valid_o && (idx_q == cnt_q - 2'd1);
  assign res_o = (idx_q == 2'd3) ? ent_q[0] : ent_q[idx_q];
  assign pop = valid_o && ready_i;
  // New results may enter once the last pending one leaves.
  assign can_load_o = !valid_o || (pop && last_o);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i && burst_i.cnt != 2'd0) begin
      cnt_d = burst_i.cnt;
      idx_d = 2'd0;
    end else if (pop) begin
      if (last_o) begin
        cnt_d = 2'd0;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && burst_i.cnt != 2'd0) begin
      ent_q <= burst_i.res;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (idx_q < cnt_q))
    else $error("result index beyond pending count");

  a_notice_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.escape_notice) |-> last_o)
    else $error("escape notice is not the final result");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && burst_i.cnt != 2'd0) |-> can_load_o)
    else $error("results loaded over pending results");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && last_o && !load_i) |=> !valid_o)
    else $error("result register not empty after final result");

endmodule

`default_nettype wire

// ----- rtl/modem_online_telnet_data_path_top.sv -----
// Top level: request register, escape and telnet logic, result register.
// Timing: a request waits in the request register until it finds the result register
// free, is processed then, and its first result is valid in the cycle after that.
// Throughput: one request per cycle while the output is ready and each has at most one
// result; results hold the result register until taken (three for a telnet refusal).
// Reset clears the mode state and the pending results; guard_ticks returns to 1000.
`default_nettype none

module modem_online_telnet_data_path_top import mtd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mtd_in_if.sink    in_i,
  mtd_out_if.source out_o,
  mtd_cfg_if.sink   cfg_i
);

  logic       req_valid_q;
  logic [2:0] opcode_q;
  logic [7:0] data_byte_q;
  logic       can_load;
  logic       step;
  mtd_burst_t burst;
  mtd_res_t   res;

  assign step = req_valid_q && can_load;
  assign in_i.ready = !req_valid_q || step;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      req_valid_q <= 1'b1;
    end else if (step) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      opcode_q    <= in_i.opcode;
      data_byte_q <= in_i.data_byte;
    end
  end

  mtd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .step_i      (step),
    .opcode_i    (opcode_q),
    .data_byte_i (data_byte_q),
    .burst_o     (burst)
  );

  mtd_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .burst_i    (burst),
    .can_load_o (can_load),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .res_o      (res),
    .last_o     (out_o.last)
  );

  assign out_o.to_network    = res.to_network;
  assign out_o.out_byte      = res.out_byte;
  assign out_o.escape_notice = res.escape_notice;

endmodule

`default_nettype wire
